FILE: design/sparse_trivariate_polynomial_arith_unit_macros.svh
// Assertion macros shared by the sparse polynomial unit.
`ifndef SPARSE_TRIVARIATE_POLYNOMIAL_ARITH_UNIT_MACROS_SVH
`define SPARSE_TRIVARIATE_POLYNOMIAL_ARITH_UNIT_MACROS_SVH

// Consequence must hold in the same cycle as the antecedent.
`define STPA_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequence must hold in the cycle after the antecedent.
`define STPA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: design/stpa_pkg.sv
// Types, codes and helper functions of the sparse polynomial unit.
`default_nettype none

package stpa_pkg;

  localparam int MAX_TERMS_DEF = 32;
  localparam int EXP_BASE_DEF  = 10;
  localparam int EXP_W         = 4;
  localparam int COEF_W        = 32;
  localparam int PACK_W        = 3 * EXP_W;
  localparam int OP_W          = PACK_W + COEF_W;
  localparam int TC_W          = 10;

  typedef enum logic [2:0] {
    ACT_CLEAR  = 3'd0,
    ACT_LOAD_A = 3'd1,
    ACT_LOAD_B = 3'd2,
    ACT_ADD    = 3'd3,
    ACT_SUB    = 3'd4,
    ACT_MUL    = 3'd5,
    ACT_EVAL   = 3'd6,
    ACT_READ   = 3'd7
  } action_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_FULL    = 2'd1,
    ST_EXP_OVF = 2'd2,
    ST_SAT     = 2'd3
  } status_t;

  typedef enum logic [4:0] {
    S_CLEAR, S_IDLE, S_DISPATCH,
    S_L_RD, S_L_CK,
    S_A_RD, S_A_WR, S_B_RD, S_B_TR, S_B_WR,
    S_OV_RD, S_OV_CK, S_M_RD, S_M_MUL, S_M_ACC,
    S_E_RD, S_E_LD, S_E_FAC, S_E_HI, S_E_FIN, S_E_SUM,
    S_R_RD, S_R_OUT, S_DONE
  } state_t;

  typedef struct packed {
    logic [2:0]        action;
    logic [3:0]        exp_x;
    logic [3:0]        exp_y;
    logic [3:0]        exp_z;
    logic signed [31:0] coefficient_in;
    logic signed [15:0] point_x;
    logic signed [15:0] point_y;
    logic signed [15:0] point_z;
  } in_item_t;

  typedef struct packed {
    logic [1:0]         status;
    logic signed [31:0] coefficient_out;
    logic               term_present;
    logic [9:0]         term_count;
    logic signed [63:0] eval_value;
  } out_item_t;

  // Dense table index of an exponent triple.
  function automatic logic [11:0] tbl_index(input logic [3:0] ex, input logic [3:0] ey,
                                            input logic [3:0] ez, input int base);
    logic [11:0] b;
    b = 12'(base);
    return (12'(ex) * b + 12'(ey)) * b + 12'(ez);
  endfunction

  // Saturate to 32 bits; the top bit of the result flags a clamp.
  function automatic logic [32:0] sat32(input logic signed [34:0] v);
    if (v > 35'sd2147483647) begin
      return {1'b1, 32'h7fff_ffff};
    end else if (v < -35'sd2147483648) begin
      return {1'b1, 32'h8000_0000};
    end else begin
      return {1'b0, v[31:0]};
    end
  endfunction

  // Magnitude of a 32-bit signed value.
  function automatic logic [31:0] abs32(input logic signed [31:0] v);
    return v[31] ? (~v + 32'd1) : v;
  endfunction

  // Magnitude of a 16-bit signed value.
  function automatic logic [15:0] abs16(input logic signed [15:0] v);
    return v[15] ? (~v + 16'd1) : v;
  endfunction

endpackage

`default_nettype wire

FILE: design/stpa_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module stpa_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

FILE: design/stpa_mul.sv
// Shared 32 by 32 unsigned multiplier with a registered product.
`default_nettype none

module stpa_mul
  import stpa_pkg::*;
(
  input  logic        clk,
  input  logic [31:0] op_a,
  input  logic [31:0] op_b,
  output logic [63:0] prod
);

  logic [63:0] prod_r;

  // One product per cycle, available the cycle after the operands.
  always_ff @(posedge clk) begin
    prod_r <= 64'(op_a) * 64'(op_b);
  end

  assign prod = prod_r;

endmodule

`default_nettype wire

FILE: design/sparse_trivariate_polynomial_arith_unit.sv
// Top level: sequencer around operand RAMs, result table RAM and a shared multiplier.
// Multiply makes one table access per pair of terms; evaluate multiplies in each
// exponent unit of a term on the shared multiplier.
// After reset a clearing pass over the result table runs before the first beat is taken.
`default_nettype none
`include "sparse_trivariate_polynomial_arith_unit_macros.svh"

module sparse_trivariate_polynomial_arith_unit
  import stpa_pkg::*;
#(
  parameter int MAX_TERMS = MAX_TERMS_DEF,
  parameter int EXP_BASE  = EXP_BASE_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  localparam int OP_AW  = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;
  localparam int CNT_W  = $clog2(MAX_TERMS + 1);
  localparam int TABLE  = EXP_BASE * EXP_BASE * EXP_BASE;
  localparam int TBL_AW = $clog2(TABLE);
  localparam int RC_W   = $clog2(TABLE + 1);
  localparam int RES_W  = COEF_W + 1;
  localparam logic [4:0] BASE5 = 5'(EXP_BASE);

  // Registers.
  state_t             state_r, state_nxt;
  in_item_t           item_r, item_nxt;
  logic [TBL_AW-1:0]  k_r, k_nxt;
  logic [CNT_W-1:0]   i_r, i_nxt, j_r, j_nxt;
  logic [CNT_W-1:0]   cnt_a_r, cnt_a_nxt, cnt_b_r, cnt_b_nxt;
  logic [RC_W-1:0]    rcount_r, rcount_nxt;
  logic               sat_r, sat_nxt, ovf_r, ovf_nxt;
  logic [TBL_AW-1:0]  idx_r, idx_nxt;
  logic signed [31:0] bco_r, bco_nxt;
  logic               sign_r, sign_nxt;
  logic [63:0]        mag_r, mag_nxt, lo_r, lo_nxt;
  logic               neg_r, neg_nxt;
  logic [3:0]         e1_r, e1_nxt, e2_r, e2_nxt, e3_r, e3_nxt;
  logic [15:0]        m_r, m_nxt;
  logic signed [63:0] eval_r, eval_nxt;
  logic [1:0]         rstat_r, rstat_nxt;
  logic signed [31:0] rcoef_r, rcoef_nxt;
  logic               rpres_r, rpres_nxt;
  out_item_t          out_r, out_nxt;
  logic               out_valid_r, out_valid_nxt;

  // Memory ports.
  logic              a_we, b_we, t_we;
  logic [OP_AW-1:0]  a_waddr, b_waddr, a_raddr, b_raddr;
  logic [OP_W-1:0]   op_wdata, a_rdata, b_rdata;
  logic [TBL_AW-1:0] t_waddr, t_raddr;
  logic [RES_W-1:0]  t_wdata, t_rdata;

  // Multiplier ports.
  logic [31:0] mul_a, mul_b;
  logic [63:0] mul_p;

  // Datapath helpers.
  action_t            act;
  logic               exp_ok, is_load_a;
  logic [CNT_W-1:0]   ld_cnt;
  logic [OP_W-1:0]    ld_word;
  logic signed [31:0] a_co, b_co, ld_co, cur;
  logic [4:0]         sx, sy, sz;
  logic               pair_ovf;
  logic [11:0]        idx_a12, idx_b12, idx_m12, idx_r12;
  logic [32:0]        sat_ld, sat_b, sat_m;
  logic signed [34:0] v_b, v_m;
  logic signed [33:0] pc;
  logic [95:0]        full;
  logic signed [63:0] term;
  logic               term_sat;
  logic signed [64:0] sum65;
  logic [15:0]        rc16;

  stpa_ram #(.WIDTH(OP_W), .DEPTH(MAX_TERMS)) u_ram_a (
    .clk(clk), .we(a_we), .waddr(a_waddr), .wdata(op_wdata), .raddr(a_raddr), .rdata(a_rdata)
  );

  stpa_ram #(.WIDTH(OP_W), .DEPTH(MAX_TERMS)) u_ram_b (
    .clk(clk), .we(b_we), .waddr(b_waddr), .wdata(op_wdata), .raddr(b_raddr), .rdata(b_rdata)
  );

  stpa_ram #(.WIDTH(RES_W), .DEPTH(TABLE)) u_ram_t (
    .clk(clk), .we(t_we), .waddr(t_waddr), .wdata(t_wdata), .raddr(t_raddr), .rdata(t_rdata)
  );

  stpa_mul u_mul (.clk(clk), .op_a(mul_a), .op_b(mul_b), .prod(mul_p));

  // Field decode and index arithmetic.
  assign act       = action_t'(item_r.action);
  assign exp_ok    = (5'(item_r.exp_x) < BASE5) && (5'(item_r.exp_y) < BASE5) &&
                     (5'(item_r.exp_z) < BASE5);
  assign is_load_a = (act == ACT_LOAD_A);
  assign ld_cnt    = is_load_a ? cnt_a_r : cnt_b_r;
  assign ld_word   = is_load_a ? a_rdata : b_rdata;
  assign a_co      = $signed(a_rdata[31:0]);
  assign b_co      = $signed(b_rdata[31:0]);
  assign ld_co     = $signed(ld_word[31:0]);
  assign cur       = t_rdata[32] ? $signed(t_rdata[31:0]) : 32'sd0;

  assign sx = 5'(a_rdata[43:40]) + 5'(b_rdata[43:40]);
  assign sy = 5'(a_rdata[39:36]) + 5'(b_rdata[39:36]);
  assign sz = 5'(a_rdata[35:32]) + 5'(b_rdata[35:32]);
  assign pair_ovf = (sx >= BASE5) || (sy >= BASE5) || (sz >= BASE5);

  assign idx_a12 = tbl_index(a_rdata[43:40], a_rdata[39:36], a_rdata[35:32], EXP_BASE);
  assign idx_b12 = tbl_index(b_rdata[43:40], b_rdata[39:36], b_rdata[35:32], EXP_BASE);
  assign idx_m12 = tbl_index(sx[3:0], sy[3:0], sz[3:0], EXP_BASE);
  assign idx_r12 = tbl_index(item_r.exp_x, item_r.exp_y, item_r.exp_z, EXP_BASE);

  // Merge on load, add or subtract of a B term, and accumulation of a product.
  assign sat_ld = sat32(35'(ld_co) + 35'(item_r.coefficient_in));
  assign v_b    = (act == ACT_ADD) ? (35'(cur) + 35'(bco_r)) : (35'(cur) - 35'(bco_r));
  assign sat_b  = sat32(v_b);

  // Product clamped to one step beyond the 32-bit range before accumulation.
  always_comb begin
    if (!sign_r) begin
      pc = (mul_p > 64'd2147483647) ? 34'sd2147483648 : $signed(mul_p[33:0]);
    end else begin
      pc = (mul_p > 64'd2147483648) ? -34'sd2147483649 : -$signed(mul_p[33:0]);
    end
  end
  assign v_m   = 35'(cur) + 35'(pc);
  assign sat_m = sat32(v_m);

  // Evaluate: wide product from two halves, then signed term and saturating sum.
  assign full = {mul_p, 32'd0} + {32'd0, lo_r};

  always_comb begin
    term_sat = 1'b0;
    if (mag_r == 64'd0) begin
      term = 64'sd0;
    end else if (neg_r) begin
      if (mag_r[63]) begin
        term     = {1'b1, 63'd0};
        term_sat = |mag_r[62:0];
      end else begin
        term = -$signed(mag_r);
      end
    end else begin
      if (mag_r[63]) begin
        term     = {1'b0, {63{1'b1}}};
        term_sat = 1'b1;
      end else begin
        term = $signed(mag_r);
      end
    end
  end
  assign sum65 = 65'(eval_r) + 65'(term);

  assign rc16 = 16'(rcount_r);

  // Next state and datapath control.
  always_comb begin
    state_nxt     = state_r;
    item_nxt      = item_r;
    k_nxt         = k_r;
    i_nxt         = i_r;
    j_nxt         = j_r;
    cnt_a_nxt     = cnt_a_r;
    cnt_b_nxt     = cnt_b_r;
    rcount_nxt    = rcount_r;
    sat_nxt       = sat_r;
    ovf_nxt       = ovf_r;
    idx_nxt       = idx_r;
    bco_nxt       = bco_r;
    sign_nxt      = sign_r;
    mag_nxt       = mag_r;
    lo_nxt        = lo_r;
    neg_nxt       = neg_r;
    e1_nxt        = e1_r;
    e2_nxt        = e2_r;
    e3_nxt        = e3_r;
    m_nxt         = m_r;
    eval_nxt      = eval_r;
    rstat_nxt     = rstat_r;
    rcoef_nxt     = rcoef_r;
    rpres_nxt     = rpres_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r;

    in_ready = 1'b0;
    a_we     = 1'b0;
    b_we     = 1'b0;
    t_we     = 1'b0;
    a_waddr  = i_r[OP_AW-1:0];
    b_waddr  = i_r[OP_AW-1:0];
    op_wdata = {item_r.exp_x, item_r.exp_y, item_r.exp_z, item_r.coefficient_in};
    a_raddr  = i_r[OP_AW-1:0];
    b_raddr  = j_r[OP_AW-1:0];
    t_waddr  = idx_r;
    t_wdata  = '0;
    t_raddr  = idx_r;
    mul_a    = abs32(a_co);
    mul_b    = abs32(b_co);

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      // Clearing pass over the result table, one entry a cycle.
      S_CLEAR: begin
        t_we    = 1'b1;
        t_waddr = k_r;
        if (k_r == TBL_AW'(TABLE - 1)) begin
          k_nxt      = '0;
          rcount_nxt = '0;
          case (act)
            ACT_ADD, ACT_SUB: state_nxt = S_A_RD;
            ACT_MUL:          state_nxt = S_OV_RD;
            default:          state_nxt = S_IDLE;
          endcase
        end else begin
          k_nxt = k_r + 1'b1;
        end
      end

      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          item_nxt  = in_data;
          i_nxt     = '0;
          j_nxt     = '0;
          sat_nxt   = 1'b0;
          ovf_nxt   = 1'b0;
          eval_nxt  = 64'sd0;
          state_nxt = S_DISPATCH;
        end
      end

      S_DISPATCH: begin
        rstat_nxt = ST_OK;
        rcoef_nxt = 32'sd0;
        rpres_nxt = 1'b0;
        case (act)
          ACT_CLEAR: begin
            cnt_a_nxt = '0;
            cnt_b_nxt = '0;
            state_nxt = S_DONE;
          end
          ACT_LOAD_A, ACT_LOAD_B: begin
            if (!exp_ok) begin
              rstat_nxt = ST_EXP_OVF;
              state_nxt = S_DONE;
            end else begin
              state_nxt = S_L_RD;
            end
          end
          ACT_ADD, ACT_SUB, ACT_MUL: begin
            k_nxt     = '0;
            state_nxt = S_CLEAR;
          end
          ACT_EVAL: state_nxt = S_E_RD;
          ACT_READ: begin
            if (!exp_ok) begin
              rstat_nxt = ST_EXP_OVF;
              state_nxt = S_DONE;
            end else begin
              state_nxt = S_R_RD;
            end
          end
          default: state_nxt = S_DONE;
        endcase
      end

      // Load: search the operand for the exponent set, then merge or append.
      S_L_RD: begin
        b_raddr = i_r[OP_AW-1:0];
        if (i_r == ld_cnt) begin
          if (ld_cnt >= CNT_W'(MAX_TERMS)) begin
            rstat_nxt = ST_FULL;
          end else begin
            a_waddr = ld_cnt[OP_AW-1:0];
            b_waddr = ld_cnt[OP_AW-1:0];
            a_we    = is_load_a;
            b_we    = !is_load_a;
            if (is_load_a) begin
              cnt_a_nxt = cnt_a_r + 1'b1;
            end else begin
              cnt_b_nxt = cnt_b_r + 1'b1;
            end
          end
          state_nxt = S_DONE;
        end else begin
          state_nxt = S_L_CK;
        end
      end

      S_L_CK: begin
        if (ld_word[43:32] == {item_r.exp_x, item_r.exp_y, item_r.exp_z}) begin
          op_wdata  = {ld_word[43:32], sat_ld[31:0]};
          a_we      = is_load_a;
          b_we      = !is_load_a;
          rstat_nxt = sat_ld[32] ? ST_SAT : ST_OK;
          state_nxt = S_DONE;
        end else begin
          i_nxt     = i_r + 1'b1;
          state_nxt = S_L_RD;
        end
      end

      // Add and subtract: copy A into the table, then fold in B.
      S_A_RD: begin
        state_nxt = (i_r == cnt_a_r) ? S_B_RD : S_A_WR;
      end

      S_A_WR: begin
        t_we       = 1'b1;
        t_waddr    = idx_a12[TBL_AW-1:0];
        t_wdata    = {1'b1, a_rdata[31:0]};
        rcount_nxt = rcount_r + 1'b1;
        i_nxt      = i_r + 1'b1;
        state_nxt  = S_A_RD;
      end

      S_B_RD: begin
        if (j_r == cnt_b_r) begin
          rstat_nxt = sat_r ? ST_SAT : ST_OK;
          state_nxt = S_DONE;
        end else begin
          state_nxt = S_B_TR;
        end
      end

      S_B_TR: begin
        t_raddr   = idx_b12[TBL_AW-1:0];
        idx_nxt   = idx_b12[TBL_AW-1:0];
        bco_nxt   = b_co;
        state_nxt = S_B_WR;
      end

      S_B_WR: begin
        t_we    = 1'b1;
        t_wdata = {1'b1, sat_b[31:0]};
        if (!t_rdata[32]) begin
          rcount_nxt = rcount_r + 1'b1;
        end
        sat_nxt   = sat_r | sat_b[32];
        j_nxt     = j_r + 1'b1;
        state_nxt = S_B_RD;
      end

      // Multiply, first pass: exponent overflow check over all pairs.
      S_OV_RD: begin
        if (i_r == cnt_a_r) begin
          i_nxt = '0;
          j_nxt = '0;
          if (ovf_r) begin
            rstat_nxt = ST_EXP_OVF;
            state_nxt = S_DONE;
          end else begin
            state_nxt = S_M_RD;
          end
        end else if (j_r == cnt_b_r) begin
          i_nxt = i_r + 1'b1;
          j_nxt = '0;
        end else begin
          state_nxt = S_OV_CK;
        end
      end

      S_OV_CK: begin
        ovf_nxt   = ovf_r | pair_ovf;
        j_nxt     = j_r + 1'b1;
        state_nxt = S_OV_RD;
      end

      // Multiply, second pass: accumulate each pair product into the table.
      S_M_RD: begin
        if (i_r == cnt_a_r) begin
          rstat_nxt = sat_r ? ST_SAT : ST_OK;
          state_nxt = S_DONE;
        end else if (j_r == cnt_b_r) begin
          i_nxt = i_r + 1'b1;
          j_nxt = '0;
        end else begin
          state_nxt = S_M_MUL;
        end
      end

      S_M_MUL: begin
        sign_nxt  = a_co[31] ^ b_co[31];
        t_raddr   = idx_m12[TBL_AW-1:0];
        idx_nxt   = idx_m12[TBL_AW-1:0];
        state_nxt = S_M_ACC;
      end

      S_M_ACC: begin
        t_we    = 1'b1;
        t_wdata = {1'b1, sat_m[31:0]};
        if (!t_rdata[32]) begin
          rcount_nxt = rcount_r + 1'b1;
        end
        sat_nxt   = sat_r | sat_m[32];
        j_nxt     = j_r + 1'b1;
        state_nxt = S_M_RD;
      end

      // Evaluate A term by term.
      S_E_RD: begin
        if (i_r == cnt_a_r) begin
          rstat_nxt = sat_r ? ST_SAT : ST_OK;
          state_nxt = S_DONE;
        end else begin
          state_nxt = S_E_LD;
        end
      end

      S_E_LD: begin
        mag_nxt = 64'(abs32(a_co));
        neg_nxt = a_co[31] ^ (item_r.point_x[15] & a_rdata[40]) ^
                  (item_r.point_y[15] & a_rdata[36]) ^ (item_r.point_z[15] & a_rdata[32]);
        e1_nxt    = a_rdata[43:40];
        e2_nxt    = a_rdata[39:36];
        e3_nxt    = a_rdata[35:32];
        state_nxt = S_E_FAC;
      end

      // Pick the next base factor and start the low half of the product, or add the term once no factor is left.
      S_E_FAC: begin
        mul_a = mag_r[31:0];
        if (e1_r != 4'd0) begin
          m_nxt     = abs16(item_r.point_x);
          e1_nxt    = e1_r - 4'd1;
          state_nxt = S_E_HI;
        end else if (e2_r != 4'd0) begin
          m_nxt     = abs16(item_r.point_y);
          e2_nxt    = e2_r - 4'd1;
          state_nxt = S_E_HI;
        end else if (e3_r != 4'd0) begin
          m_nxt     = abs16(item_r.point_z);
          e3_nxt    = e3_r - 4'd1;
          state_nxt = S_E_HI;
        end else begin
          state_nxt = S_E_SUM;
        end
        mul_b = {16'd0, m_nxt};
      end

      S_E_HI: begin
        lo_nxt    = mul_p;
        mul_a     = mag_r[63:32];
        mul_b     = {16'd0, m_r};
        state_nxt = S_E_FIN;
      end

      S_E_FIN: begin
        mag_nxt   = (|full[95:64]) ? {64{1'b1}} : full[63:0];
        state_nxt = S_E_FAC;
      end

      S_E_SUM: begin
        if (sum65[64] != sum65[63]) begin
          eval_nxt = sum65[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
          sat_nxt  = 1'b1;
        end else begin
          eval_nxt = sum65[63:0];
          sat_nxt  = sat_r | term_sat;
        end
        i_nxt     = i_r + 1'b1;
        state_nxt = S_E_RD;
      end

      // Read one table entry.
      S_R_RD: begin
        t_raddr   = idx_r12[TBL_AW-1:0];
        state_nxt = S_R_OUT;
      end

      S_R_OUT: begin
        rpres_nxt = t_rdata[32];
        rcoef_nxt = t_rdata[32] ? $signed(t_rdata[31:0]) : 32'sd0;
        state_nxt = S_DONE;
      end

      // Hand the result to the output register once it is free.
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_nxt.status          = rstat_r;
          out_nxt.coefficient_out = rcoef_r;
          out_nxt.term_present    = rpres_r;
          out_nxt.term_count      = rc16[TC_W-1:0];
          out_nxt.eval_value      = eval_r;
          out_valid_nxt           = 1'b1;
          state_nxt               = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  // State and datapath registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      item_r      <= '0;
      k_r         <= '0;
      i_r         <= '0;
      j_r         <= '0;
      cnt_a_r     <= '0;
      cnt_b_r     <= '0;
      rcount_r    <= '0;
      sat_r       <= 1'b0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      item_r      <= item_nxt;
      k_r         <= k_nxt;
      i_r         <= i_nxt;
      j_r         <= j_nxt;
      cnt_a_r     <= cnt_a_nxt;
      cnt_b_r     <= cnt_b_nxt;
      rcount_r    <= rcount_nxt;
      sat_r       <= sat_nxt;
      ovf_r       <= ovf_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r   <= idx_nxt;
    bco_r   <= bco_nxt;
    sign_r  <= sign_nxt;
    mag_r   <= mag_nxt;
    lo_r    <= lo_nxt;
    neg_r   <= neg_nxt;
    e1_r    <= e1_nxt;
    e2_r    <= e2_nxt;
    e3_r    <= e3_nxt;
    m_r     <= m_nxt;
    eval_r  <= eval_nxt;
    rstat_r <= rstat_nxt;
    rcoef_r <= rcoef_nxt;
    rpres_r <= rpres_nxt;
    out_r   <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // Checks on the sequencer.
  `STPA_ASSERT_NEXT(a_busy_after_beat, clk, rst_n, in_valid && in_ready, !in_ready, "ready after beat")
  `STPA_ASSERT_SAME(a_result_count, clk, rst_n, 1'b1, rcount_r <= RC_W'(TABLE), "table count overflow")
  `STPA_ASSERT_SAME(a_operand_count, clk, rst_n, 1'b1, (cnt_a_r <= CNT_W'(MAX_TERMS)) && (cnt_b_r <= CNT_W'(MAX_TERMS)), "operand count overflow")
  `STPA_ASSERT_SAME(a_out_from_done, clk, rst_n, $rose(out_valid_r), $past(state_r == S_DONE), "result without finish")

endmodule

`default_nettype wire
